>>> src/uhist_pkg.sv
// Shared types and constants for the uniform-bin histogram.
package uhist_pkg;

  localparam int MAX_BINS_DEF = 16;
  localparam int ALU_W        = 34;
  localparam int BIN_NUM_W    = 5;
  localparam int BIN_COUNT_W  = 5;
  localparam int CFG_DATA_W   = 32;

  typedef logic [1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_RANGE_START = 2'd0;
  localparam cfg_idx_t CFG_RANGE_END   = 2'd1;
  localparam cfg_idx_t CFG_BIN_COUNT   = 2'd2;

  localparam logic [31:0] RST_RANGE_START = 32'd0;
  localparam logic [31:0] RST_RANGE_END   = 32'd16;
  localparam logic [BIN_COUNT_W-1:0] RST_BIN_COUNT = 5'd16;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic                 command;
    logic [31:0]          sample_index;
    logic [31:0]          addend;
    logic [BIN_NUM_W-1:0] read_bin;
  } in_t;

  typedef struct packed {
    logic [BIN_NUM_W-1:0] bin_number;
    logic [63:0]          bin_value;
    logic                 was_clamped;
    logic                 bin_exists;
  } out_t;

  // Request from the sequencer to the counter store.
  typedef struct packed {
    logic                 command;
    logic [BIN_NUM_W-1:0] bin_number;
    logic [31:0]          addend;
    logic                 was_clamped;
    logic                 bin_exists;
  } req_t;

endpackage

>>> src/uhist_alu.sv
// Shared add/subtract unit with borrow flag.
module uhist_alu (
  input  logic [uhist_pkg::ALU_W-1:0] a,
  input  logic [uhist_pkg::ALU_W-1:0] b,
  input  logic                        sub,
  output logic [uhist_pkg::ALU_W-1:0] result,
  output logic                        borrow
);

  localparam int AW = uhist_pkg::ALU_W;

  logic [AW:0] full;

  assign full   = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{AW{1'b0}}, sub};
  assign result = full[AW-1:0];
  assign borrow = sub & ~full[AW];

endmodule

>>> src/uhist_ctrl.sv
// Sequencer: bin geometry by long division, then a bin walk per add.
module uhist_ctrl #(
  parameter int MAX_BINS = uhist_pkg::MAX_BINS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr,
  input  logic [31:0]                         range_start,
  input  logic [31:0]                         range_end,
  input  logic [uhist_pkg::BIN_COUNT_W-1:0]   bin_count,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  uhist_pkg::in_t                      in_data,
  output logic                                req_valid,
  input  logic                                req_ready,
  output uhist_pkg::req_t                     req,
  output logic [$clog2(MAX_BINS+1)-1:0]       req_addr
);

  localparam int AW  = uhist_pkg::ALU_W;
  localparam int NW  = $clog2(MAX_BINS + 1);
  localparam int BNW = uhist_pkg::BIN_NUM_W;
  localparam logic [5:0] DIV_STEPS = 6'd33;

  typedef enum logic [3:0] {
    S_GDOM, S_GNUM, S_GDIV1, S_GSET, S_GDIV2, S_GEND,
    S_IDLE, S_OFF, S_WALK, S_REQ
  } state_t;

  state_t state;

  logic [31:0]   domain;
  logic [31:0]   width;
  logic [31:0]   rem_bin;
  logic [NW-1:0] last_bin;
  logic [31:0]   div_rem;
  logic [32:0]   div_quo;
  logic [5:0]    div_cnt;
  logic [31:0]   off;
  logic [NW-1:0] walk_i;
  logic [31:0]   item_idx;
  logic [31:0]   item_addend;

  logic [NW-1:0] n_eff;
  logic [NW-1:0] n_minus1;
  logic [32:0]   rem_sh;
  logic          rd_ok;

  logic [AW-1:0] alu_a;
  logic [AW-1:0] alu_b;
  logic          alu_sub;
  logic [AW-1:0] alu_res;
  logic          alu_borrow;

  logic          issue_go;
  logic [NW-1:0] issue_sel;
  logic          issue_clamp;

  uhist_alu u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .sub    (alu_sub),
    .result (alu_res),
    .borrow (alu_borrow)
  );

  // Zero acts as one bin; clamp to the store size.
  always_comb begin
    if (bin_count == '0) begin
      n_eff = NW'(1);
    end else if (32'(bin_count) > 32'(MAX_BINS)) begin
      n_eff = NW'(MAX_BINS);
    end else begin
      n_eff = NW'(bin_count);
    end
  end

  assign n_minus1 = n_eff - NW'(1);
  assign rem_sh   = {div_rem, div_quo[32]};
  assign rd_ok    = 32'(in_data.read_bin) <= 32'(last_bin);

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;
    case (state)
      S_GDOM: begin
        alu_a = AW'(range_end);
        alu_b = AW'(range_start);
      end
      S_GNUM: begin
        alu_a   = AW'(domain);
        alu_b   = AW'(n_minus1);
        alu_sub = 1'b0;
      end
      S_GDIV1: begin
        alu_a = AW'(rem_sh);
        alu_b = AW'(n_eff);
      end
      S_GDIV2: begin
        alu_a = AW'(rem_sh);
        alu_b = AW'(width);
      end
      S_OFF: begin
        alu_a = AW'(item_idx);
        alu_b = AW'(range_start);
      end
      S_WALK: begin
        alu_a = AW'(off);
        // the bin after the uniform ones is the partial bin
        alu_b = (walk_i == n_eff) ? AW'(rem_bin) : AW'(width);
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  always_comb begin
    issue_go    = 1'b0;
    issue_sel   = '0;
    issue_clamp = 1'b0;
    case (state)
      S_OFF: begin
        if (alu_borrow) begin
          issue_go    = 1'b1;
          issue_clamp = 1'b1;
        end else if (width == '0) begin
          issue_go    = 1'b1;
          issue_sel   = n_minus1;
          issue_clamp = 1'b1;
        end
      end
      S_WALK: begin
        if (alu_borrow) begin
          issue_go  = 1'b1;
          issue_sel = walk_i;
        end else if (walk_i == last_bin) begin
          issue_go    = 1'b1;
          issue_sel   = last_bin;
          issue_clamp = 1'b1;
        end
      end
      default: begin
        issue_go = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_GDOM;
    end else if (cfg_wr) begin
      state <= S_GDOM;
    end else begin
      case (state)
        S_GDOM: begin
          domain <= alu_res[31:0];
          state  <= S_GNUM;
        end
        S_GNUM: begin
          div_rem <= '0;
          div_quo <= alu_res[32:0];
          div_cnt <= DIV_STEPS;
          state   <= S_GDIV1;
        end
        S_GDIV1, S_GDIV2: begin
          div_quo <= {div_quo[31:0], ~alu_borrow};
          div_rem <= alu_borrow ? rem_sh[31:0] : alu_res[31:0];
          div_cnt <= div_cnt - 6'd1;
          if (div_cnt == 6'd1) begin
            state <= (state == S_GDIV1) ? S_GSET : S_GEND;
          end
        end
        S_GSET: begin
          width <= div_quo[31:0];
          if (div_quo[31:0] == '0) begin
            rem_bin  <= '0;
            last_bin <= n_minus1;
            state    <= S_IDLE;
          end else begin
            div_rem <= '0;
            div_quo <= {1'b0, domain};
            div_cnt <= DIV_STEPS;
            state   <= S_GDIV2;
          end
        end
        S_GEND: begin
          rem_bin  <= div_rem;
          last_bin <= (div_rem != '0) ? n_eff : n_minus1;
          state    <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            item_idx    <= in_data.sample_index;
            item_addend <= in_data.addend;
            if (in_data.command == uhist_pkg::CMD_READ) begin
              req.command     <= uhist_pkg::CMD_READ;
              req.bin_number  <= in_data.read_bin;
              req.addend      <= in_data.addend;
              req.was_clamped <= 1'b0;
              req.bin_exists  <= rd_ok;
              req_addr        <= rd_ok ? NW'(in_data.read_bin) : '0;
              state           <= S_REQ;
            end else begin
              state <= S_OFF;
            end
          end
        end
        S_OFF, S_WALK: begin
          if (issue_go) begin
            req.command     <= uhist_pkg::CMD_ADD;
            req.bin_number  <= BNW'(issue_sel);
            req.addend      <= item_addend;
            req.was_clamped <= issue_clamp;
            req.bin_exists  <= 1'b1;
            req_addr        <= issue_sel;
            state           <= S_REQ;
          end else begin
            off <= alu_res[31:0];
            if (state == S_OFF) begin
              walk_i <= '0;
              state  <= S_WALK;
            end else begin
              walk_i <= walk_i + NW'(1);
            end
          end
        end
        S_REQ: begin
          if (req_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_GDOM;
        end
      endcase
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign req_valid = (state == S_REQ);

endmodule

>>> src/uhist_bins.sv
// Bin counter store: registered read, then add and write back.
module uhist_bins #(
  parameter int MAX_BINS = uhist_pkg::MAX_BINS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  uhist_pkg::req_t               req,
  input  logic [$clog2(MAX_BINS+1)-1:0] req_addr,
  output logic                          res_valid,
  input  logic                          res_ready,
  output uhist_pkg::out_t               res
);

  localparam int DEPTH = MAX_BINS + 1;
  localparam int NW    = $clog2(DEPTH);

  logic [63:0]      mem [DEPTH];
  logic [DEPTH-1:0] vld;

  logic             pending;
  uhist_pkg::req_t  hold;
  logic [NW-1:0]    hold_addr;
  logic [63:0]      rd_data;
  logic             rd_hit;

  logic             take;
  logic             wr_en;
  logic [63:0]      cur;
  logic [63:0]      sum;

  assign req_ready = ~pending;
  assign take      = req_valid & ~pending;
  assign res_valid = pending & res_ready;
  assign wr_en     = res_valid & (hold.command == uhist_pkg::CMD_ADD);

  // A bin never written since reset reads as zero.
  assign cur = rd_hit ? rd_data : '0;
  assign sum = cur + 64'(hold.addend);

  always_ff @(posedge clk) begin
    if (take) begin
      rd_data <= mem[req_addr];
    end
    if (wr_en) begin
      mem[hold_addr] <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      pending <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[hold_addr] <= 1'b1;
      end
      if (take) begin
        pending <= 1'b1;
      end else if (res_valid) begin
        pending <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold      <= req;
      hold_addr <= req_addr;
      rd_hit    <= vld[req_addr];
    end
  end

  always_comb begin
    res.bin_number  = hold.bin_number;
    res.was_clamped = hold.was_clamped;
    res.bin_exists  = hold.bin_exists;
    if (hold.command == uhist_pkg::CMD_ADD) begin
      res.bin_value = sum;
    end else if (hold.bin_exists) begin
      res.bin_value = cur;
    end else begin
      res.bin_value = '0;
    end
  end

endmodule

>>> src/uniform_bin_histogram.sv
// An add passes the offset subtraction, the bin walk, the counter store and the output
// register; a read goes straight to the counter store. One item at a time; the bin walk
// through the shared subtractor sets the add rate, and the next item is taken as soon as
// the counter store has the request. Reset, and every configuration write, start
// a geometry pass (two 33-step divisions; one for an empty range), in_ready low.
// Reset clears the configuration to its defaults and all bin counts to zero.
module uniform_bin_histogram #(
  parameter int MAX_BINS = uhist_pkg::MAX_BINS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  uhist_pkg::cfg_idx_t             cfg_index,
  input  logic [uhist_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  uhist_pkg::in_t                  in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output uhist_pkg::out_t                 out_data
);

  localparam int NW = $clog2(MAX_BINS + 1);

  logic [31:0]                       range_start;
  logic [31:0]                       range_end;
  logic [uhist_pkg::BIN_COUNT_W-1:0] bin_count;
  logic                              cfg_wr;

  logic            req_valid;
  logic            req_ready;
  uhist_pkg::req_t req;
  logic [NW-1:0]   req_addr;
  logic            res_valid;
  logic            res_ready;
  uhist_pkg::out_t res;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_start <= uhist_pkg::RST_RANGE_START;
      range_end   <= uhist_pkg::RST_RANGE_END;
      bin_count   <= uhist_pkg::RST_BIN_COUNT;
    end else if (cfg_wr) begin
      case (cfg_index)
        uhist_pkg::CFG_RANGE_START: range_start <= cfg_data;
        uhist_pkg::CFG_RANGE_END:   range_end   <= cfg_data;
        uhist_pkg::CFG_BIN_COUNT:   bin_count   <= cfg_data[uhist_pkg::BIN_COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  uhist_ctrl #(
    .MAX_BINS (MAX_BINS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr      (cfg_wr),
    .range_start (range_start),
    .range_end   (range_end),
    .bin_count   (bin_count),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .req_addr    (req_addr)
  );

  uhist_bins #(
    .MAX_BINS (MAX_BINS)
  ) u_bins (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .req_addr  (req_addr),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: hold a finished transaction until it is taken.
  assign res_ready = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data <= res;
    end
  end

  a_cfg_blocks_input : assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !in_ready)
    else $error("input accepted right after a configuration write");

  a_one_item_at_a_time : assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready again in the cycle after an accept");

  a_missing_bin_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.bin_exists |-> out_data.bin_value == 64'd0)
    else $error("read of an undefined bin returned a nonzero count");

  a_clamp_only_on_add : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.was_clamped |-> out_data.bin_exists)
    else $error("clamped result without an existing bin");

endmodule

>>> sim/uniform_bin_histogram_tb.sv
// Self-checking testbench for the uniform-bin histogram: bin predictor, driver and monitor.
module uniform_bin_histogram_tb;

  localparam int BINS = uhist_pkg::MAX_BINS_DEF;
  localparam int BNW = uhist_pkg::BIN_NUM_W;
  localparam uhist_pkg::cfg_idx_t CFG_UNUSED = 2'd3;
  localparam int RUN_LIMIT = 8_000_000;
  localparam int RANDOM_PHASES = 10;
  localparam int HALF_PHASE = 40;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  uhist_pkg::cfg_idx_t              cfg_index = uhist_pkg::CFG_RANGE_START;
  logic [uhist_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  uhist_pkg::in_t                   in_data = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  uhist_pkg::out_t                  out_data;

  // Predicted block state, updated at each accepted transaction.
  logic [31:0]                       cfg_range_start;
  logic [31:0]                       cfg_range_end;
  logic [uhist_pkg::BIN_COUNT_W-1:0] cfg_bin_count;
  bit [63:0]                         bin_totals [0:BINS];

  uhist_pkg::in_t  pending_items [$];
  uhist_pkg::out_t expected_results [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          in_taken = 1'b0;
  int          failures = 0;
  int          adds_sent = 0;
  int          reads_sent = 0;
  int          clamped_seen = 0;
  int          missing_bins_seen = 0;
  int          cfg_writes = 0;
  int          settings_used = 0;

  uniform_bin_histogram i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  function automatic void bin_geometry(output bit [63:0] width, output bit [63:0] rem,
                                       output int unsigned n, output int unsigned total);
    bit [63:0] domain;
    n = (cfg_bin_count == 0) ? 1 : (cfg_bin_count > BINS) ? BINS : cfg_bin_count;
    domain = {32'd0, 32'(cfg_range_end - cfg_range_start)};
    width = (domain + n - 1) / n;
    rem = (width != 0) ? domain % width : 64'd0;
    total = n + ((rem != 0) ? 1 : 0);
  endfunction

  // Locate the bin, accumulate, and return the result the block should report.
  function automatic uhist_pkg::out_t histogram_update(uhist_pkg::in_t item);
    uhist_pkg::out_t res;
    bit [63:0] width, rem, lo, size;
    int unsigned n, total, sel;
    bit        found;
    bin_geometry(width, rem, n, total);
    res = '0;
    if (item.command == uhist_pkg::CMD_READ) begin
      res.bin_number = item.read_bin;
      res.bin_exists = (item.read_bin < total);
      res.bin_value  = res.bin_exists ? bin_totals[item.read_bin] : 64'd0;
      return res;
    end
    found = 1'b0;
    sel = 0;
    for (int i = 0; i < total; i++) begin
      size = (i < n) ? width : rem;
      lo = {32'd0, cfg_range_start} + 64'(i) * width;
      if (!found && {32'd0, item.sample_index} >= lo &&
          {32'd0, item.sample_index} < lo + size) begin
        found = 1'b1;
        sel = i;
      end
    end
    if (!found) sel = (item.sample_index < cfg_range_start) ? 0 : total - 1;
    bin_totals[sel] += {32'd0, item.addend};
    res.bin_number  = sel[BNW-1:0];
    res.bin_value   = bin_totals[sel];
    res.was_clamped = !found;
    res.bin_exists  = 1'b1;
    return res;
  endfunction

  function automatic void queue_item(uhist_pkg::in_t it);
    pending_items = {pending_items, it};
  endfunction

  function automatic uhist_pkg::in_t add_item(logic [31:0] idx, logic [31:0] amount);
    uhist_pkg::in_t it;
    it.command      = uhist_pkg::CMD_ADD;
    it.sample_index = idx;
    it.addend       = amount;
    it.read_bin     = BNW'($urandom);
    return it;
  endfunction

  function automatic uhist_pkg::in_t read_item(logic [BNW-1:0] bin);
    uhist_pkg::in_t it;
    it.command      = uhist_pkg::CMD_READ;
    it.sample_index = $urandom;
    it.addend       = $urandom;
    it.read_bin     = bin;
    return it;
  endfunction

  // Aim most indices at bin edges or inside the binned span, the rest anywhere.
  function automatic uhist_pkg::in_t random_item();
    uhist_pkg::in_t it;
    bit [63:0] width, rem, off;
    int unsigned n, total, pick;
    bin_geometry(width, rem, n, total);
    it.command  = ($urandom_range(99) < 35) ? uhist_pkg::CMD_READ : uhist_pkg::CMD_ADD;
    it.read_bin = ($urandom_range(9) == 0) ? BNW'($urandom_range(31))
                                          : BNW'($urandom_range(total + 1));
    pick = $urandom_range(9);
    if (pick < 5)
      off = 64'($urandom_range(total)) * width + 64'($urandom_range(2)) - 64'd1;
    else if (pick < 8)
      off = {$urandom, $urandom} % (64'(n) * width + rem + 64'd2);
    else
      off = 64'($urandom - cfg_range_start);
    it.sample_index = cfg_range_start + off[31:0];
    case ($urandom_range(3))
      0:       it.addend = 32'hFFFF_FFFF;
      1:       it.addend = $urandom_range(15);
      default: it.addend = $urandom;
    endcase
    return it;
  endfunction

  function automatic void note_failure(string msg);
    failures++;
    if (failures <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // Driver: present the next pending transaction once the current one is taken.
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= pending_items.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: track configuration, predict each accepted item, check each result.
  always @(posedge clk) begin : monitor
    uhist_pkg::out_t want;
    uhist_pkg::out_t predicted;
    in_taken = in_valid && in_ready && !rst;
    if (rst) begin
      cfg_range_start = uhist_pkg::RST_RANGE_START;
      cfg_range_end   = uhist_pkg::RST_RANGE_END;
      cfg_bin_count   = uhist_pkg::RST_BIN_COUNT;
      foreach (bin_totals[i]) bin_totals[i] = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg_writes++;
        case (cfg_index)
          uhist_pkg::CFG_RANGE_START: cfg_range_start = cfg_data;
          uhist_pkg::CFG_RANGE_END:   cfg_range_end = cfg_data;
          uhist_pkg::CFG_BIN_COUNT:   cfg_bin_count = cfg_data[uhist_pkg::BIN_COUNT_W-1:0];
          default: ;
        endcase
      end
      if (in_taken) begin
        if (in_data.command == uhist_pkg::CMD_READ) reads_sent++;
        else adds_sent++;
        predicted = histogram_update(in_data);
        expected_results = {expected_results, predicted};
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          note_failure($sformatf("unexpected result: bin %0d value %h clamped %b exists %b",
                                 out_data.bin_number, out_data.bin_value,
                                 out_data.was_clamped, out_data.bin_exists));
        end else begin
          want = expected_results.pop_front();
          if (want.was_clamped) clamped_seen++;
          if (!want.bin_exists) missing_bins_seen++;
          if (out_data.bin_number !== want.bin_number || out_data.bin_value !== want.bin_value ||
              out_data.was_clamped !== want.was_clamped ||
              out_data.bin_exists !== want.bin_exists)
            note_failure($sformatf(
              "expected bin %0d value %h clamped %b exists %b, got bin %0d value %h clamped %b exists %b",
              want.bin_number, want.bin_value, want.was_clamped, want.bin_exists,
              out_data.bin_number, out_data.bin_value, out_data.was_clamped,
              out_data.bin_exists));
        end
      end
    end
  end

  task automatic write_reg(uhist_pkg::cfg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_setting(logic [31:0] start, logic [31:0] stop, logic [31:0] count_word,
                               bit with_noise);
    write_reg(uhist_pkg::CFG_RANGE_START, start);
    if (with_noise) write_reg(CFG_UNUSED, $urandom);
    write_reg(uhist_pkg::CFG_RANGE_END, stop);
    write_reg(uhist_pkg::CFG_BIN_COUNT, count_word);
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic wait_results_drained();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  initial begin : stimulus
    logic [31:0] start, stop, count_word;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Default geometry: sixteen unit bins over [0, 16).
    queue_item(add_item(32'd0, 32'hFFFF_FFFF));
    queue_item(add_item(32'd0, 32'hFFFF_FFFF));
    queue_item(add_item(32'd15, 32'd1));
    queue_item(add_item(32'd16, 32'd7));
    queue_item(add_item(32'hFFFF_FFFF, 32'd3));
    queue_item(add_item(32'd7, 32'd0));
    queue_item(read_item(5'd0));
    queue_item(read_item(5'd15));
    queue_item(read_item(5'd16));
    queue_item(read_item(5'd31));
    queue_item(read_item(5'd7));
    wait_results_drained();

    // Empty range: everything clamps to the first or the last bin.
    apply_setting(32'd1000, 32'd1000, 32'd5, 1'b0);
    queue_item(add_item(32'd999, 32'd1));
    queue_item(add_item(32'd1000, 32'd2));
    queue_item(add_item(32'd0, 32'd1));
    queue_item(read_item(5'd4));
    queue_item(read_item(5'd5));
    wait_results_drained();

    // Domain 23 over five bins of width 5 leaves a partial bin of size 3.
    apply_setting(32'd10, 32'd33, 32'd5, 1'b0);
    queue_item(add_item(32'd9, 32'd1));
    queue_item(add_item(32'd10, 32'd1));
    queue_item(add_item(32'd34, 32'd1));
    queue_item(add_item(32'd35, 32'd1));
    queue_item(add_item(32'd37, 32'd1));
    queue_item(add_item(32'd38, 32'd1));
    queue_item(read_item(5'd5));
    queue_item(read_item(5'd6));
    wait_results_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      count_word = $urandom & 32'hFFFF_FFE0;
      case (p)
        0: begin start = 32'd0;         stop = 32'hFFFF_FFFF; count_word |= 32'd16; end
        1: begin start = 32'hFFFF_FFFF; stop = 32'd0;         count_word |= 32'd31; end
        2: begin start = 32'hFFFF_FFF0; stop = 32'h0000_0010; count_word |= 32'd0;  end
        3: begin start = 32'd12345;     stop = 32'd12445;     count_word |= 32'd17; end
        default: begin
          start = $urandom;
          case ($urandom_range(3))
            0:       stop = start + $urandom_range(60, 1);
            1:       stop = $urandom;
            2:       stop = start;
            default: stop = start - $urandom_range(60, 1);
          endcase
          count_word |= $urandom_range(31);
        end
      endcase
      apply_setting(start, stop, count_word, p == 1);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      repeat (HALF_PHASE) queue_item(random_item());
      // Hold the sender until every result of the first half is back.
      wait_results_drained();
      repeat (HALF_PHASE) queue_item(random_item());
      wait_results_drained();
      send_idle_pct = 0;
      recv_stall_pct = 0;
    end

    repeat (40) @(posedge clk);
    if (expected_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", expected_results.size()));
    $display("Covered %0d adds and %0d reads under %0d geometries (%0d config writes).",
             adds_sent, reads_sent, settings_used + 1, cfg_writes);
    $display("Saw %0d clamped adds and %0d reads of undefined bins; %0d mismatches.",
             clamped_seen, missing_bins_seen, failures);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT);
    $display("ERROR: run did not finish within the time limit");
    $display("Test completed with failures");
    $finish;
  end

endmodule
